/* design/rhs_pkg.sv */
package rhs_pkg;

    localparam int POS_W = 19;

    localparam logic [POS_W-1:0] POS_MAX      = '1;
    localparam logic [POS_W-1:0] FIXED_HDR    = POS_W'(12);
    localparam logic [POS_W-1:0] EXT_HDR      = POS_W'(4);

    localparam logic [6:0] DEFAULT_PT = 7'd96;
    localparam logic [1:0] VERSION_TWO = 2'b10;

    // end-of-packet status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_SHORT     = 3'd1;
    localparam logic [2:0] ST_VERSION   = 3'd2;
    localparam logic [2:0] ST_TYPE      = 3'd3;
    localparam logic [2:0] ST_TRUNCATED = 3'd4;

    // parse phases
    localparam logic [1:0] PH_FIXED   = 2'd0;
    localparam logic [1:0] PH_EXT_HDR = 2'd1;
    localparam logic [1:0] PH_BODY    = 2'd2;

endpackage

/* design/rtp_header_stripper.sv */
// Strips the RTP header from a packet that arrives one byte per transfer, tlast on its final
// byte. Byte 0 must carry version 2 and gives the CSRC count and extension bit; byte 1 must
// carry the payload type held in the configuration register (reset 96). The fixed 12-byte
// header, 4 bytes per CSRC and, if flagged, the extension header and its body are dropped;
// later bytes leave as payload (m_tuser[0] set). The final byte always yields a transfer with
// m_tlast and a status in m_tuser[3:1]: 0 ok, 1 shorter than 12 bytes, 2 bad version,
// 3 wrong payload type, 4 truncated header or no payload. Header bytes other than the final
// one give no output transfer. The block takes one byte every cycle through a single output
// register, which sets the pace, and s_tready falls only while that register holds
// a transfer the sink has not taken. Write the payload type only while no packet is in flight.
module rtp_header_stripper
    import rhs_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       cfg_wr_en,
    input  logic [6:0] cfg_wr_data,

    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] data_byte
    input  logic       s_tlast,

    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [7:0] out_byte
    output logic [3:0] m_tuser,    // [0] out_valid, [3:1] status
    output logic       m_tlast
);

    logic [6:0]       pt_reg;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] hend_reg, hend_next;
    logic             ext_reg, ext_next;
    logic [7:0]       elh_reg, elh_next;
    logic [2:0]       perr_reg, perr_next;
    logic [1:0]       phase_reg, phase_next;

    logic             mval_reg;
    logic [7:0]       mbyte_reg;
    logic             mpay_reg;
    logic             mlast_reg;
    logic [2:0]       mstat_reg;

    logic             accept;
    logic             payload;
    logic [2:0]       status;
    logic [POS_W:0]   len;

    assign s_tready = !mval_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign len      = {1'b0, pos_reg} + (POS_W+1)'(1);

    always_comb begin
        hend_next  = hend_reg;
        ext_next   = ext_reg;
        elh_next   = elh_reg;
        perr_next  = perr_reg;
        phase_next = phase_reg;

        if (pos_reg == '0) begin
            hend_next  = FIXED_HDR + POS_W'({s_tdata[3:0], 2'b00});
            ext_next   = s_tdata[4];
            elh_next   = '0;
            perr_next  = (s_tdata[7:6] != VERSION_TWO) ? ST_VERSION : ST_OK;
            phase_next = PH_FIXED;
        end else if (pos_reg == POS_W'(1)) begin
            if (perr_reg == ST_OK && s_tdata[6:0] != pt_reg) begin
                perr_next = ST_TYPE;
            end
        end

        if (phase_next == PH_FIXED && pos_reg >= hend_next) begin
            if (ext_next) begin
                phase_next = PH_EXT_HDR;
                hend_next  = hend_next + EXT_HDR;
            end else begin
                phase_next = PH_BODY;
            end
        end

        // the last two bytes of the extension header give its length in words
        if (phase_next == PH_EXT_HDR) begin
            if ({1'b0, pos_reg} + (POS_W+1)'(2) == {1'b0, hend_next}) begin
                elh_next = s_tdata;
            end else if (len == {1'b0, hend_next}) begin
                hend_next  = hend_next + POS_W'({elh_next, s_tdata, 2'b00});
                phase_next = PH_BODY;
            end
        end

        payload = phase_next == PH_BODY && pos_reg >= hend_next && perr_next == ST_OK;

        if (len < {1'b0, FIXED_HDR}) begin
            status = ST_SHORT;
        end else if (perr_next != ST_OK) begin
            status = perr_next;
        end else if (phase_next != PH_BODY || len <= {1'b0, hend_next}) begin
            status = ST_TRUNCATED;
        end else begin
            status = ST_OK;
        end

        pos_next = (pos_reg != POS_MAX) ? len[POS_W-1:0] : POS_MAX;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pt_reg    <= DEFAULT_PT;
            pos_reg   <= '0;
            hend_reg  <= FIXED_HDR;
            ext_reg   <= 1'b0;
            elh_reg   <= '0;
            perr_reg  <= ST_OK;
            phase_reg <= PH_FIXED;
        end else begin
            if (cfg_wr_en) begin
                pt_reg <= cfg_wr_data;
            end
            if (accept) begin
                if (s_tlast) begin
                    pos_reg   <= '0;
                    hend_reg  <= FIXED_HDR;
                    ext_reg   <= 1'b0;
                    elh_reg   <= '0;
                    perr_reg  <= ST_OK;
                    phase_reg <= PH_FIXED;
                end else begin
                    pos_reg   <= pos_next;
                    hend_reg  <= hend_next;
                    ext_reg   <= ext_next;
                    elh_reg   <= elh_next;
                    perr_reg  <= perr_next;
                    phase_reg <= phase_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mval_reg <= 1'b0;
        end else if (s_tready) begin
            mval_reg <= accept && (payload || s_tlast);
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready) begin
            mbyte_reg <= payload ? s_tdata : 8'd0;
            mpay_reg  <= payload;
            mlast_reg <= s_tlast;
            mstat_reg <= s_tlast ? status : ST_OK;
        end
    end

    assign m_tvalid = mval_reg;
    assign m_tdata  = mbyte_reg;
    assign m_tuser  = {mstat_reg, mpay_reg};
    assign m_tlast  = mlast_reg;

endmodule

/* design/rhs_checker.sv */
module rhs_checker
    import rhs_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [3:0] m_tuser,
    input logic       m_tlast
);

    // a stalled transfer holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("output transfer changed while stalled");

    a_useful: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser[0] || m_tlast)
        else $error("transfer carries neither payload nor end marker");

    a_status_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tuser[3:1] == ST_OK)
        else $error("status set without end marker");

    // payload only follows a good header, so a payload end byte is always ok
    a_payload_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tuser[3:1] == ST_OK)
        else $error("payload with error status");

    a_zero_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == 8'd0)
        else $error("non-payload transfer carries data");

endmodule

bind rtp_header_stripper rhs_checker u_rhs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

/* tb/sv/rtp_header_stripper_test.sv */
`timescale 1ns / 100ps

module rtp_header_stripper_test;
    import rhs_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SINK_HOLD      = 400;
    localparam int PHASE_ITEMS    = 375;
    localparam int LONG_LEN       = 64;

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       last;
        logic [2:0] status;
    } strip_out_t;

    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       typed;
        strip_out_t want;
    } dir_row_t;

    logic       aclk;
    logic       aresetn;
    logic       cfg_wr_en;
    logic [6:0] cfg_wr_data;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;    // [7:0] data_byte
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;    // [7:0] out_byte
    logic [3:0] m_tuser;    // [0] out_valid, [3:1] status
    logic       m_tlast;

    // shadow of the parser state
    logic [6:0]       pt_cfg;
    logic [POS_W-1:0] pos_q;
    logic [POS_W-1:0] hdr_end_q;
    logic             ext_q;
    logic [7:0]       ext_hi_q;
    logic [2:0]       err_q;
    logic [1:0]       phase_q;

    strip_out_t pending_out[$];
    dir_row_t   dir_tab[$];

    int  fail_count  = 0;
    int  items_sent  = 0;
    int  burst_left  = 0;
    int  idle_cycles = 0;
    bit  src_steady  = 1'b0;
    bit  sink_steady = 1'b0;
    bit  sink_hold_req = 1'b0;

    rtp_header_stripper u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    function automatic void clear_parse();
        pos_q     = '0;
        hdr_end_q = FIXED_HDR;
        ext_q     = 1'b0;
        ext_hi_q  = '0;
        err_q     = ST_OK;
        phase_q   = PH_FIXED;
    endfunction

    function automatic logic strip_predict(input logic [7:0] b, input logic lst,
                                           output strip_out_t x);
        int         pos;
        int         len;
        logic       pay;
        logic [2:0] st;
        pos = int'(pos_q);
        st  = ST_OK;
        if (pos == 0) begin
            hdr_end_q = POS_W'(int'(FIXED_HDR) + 4 * int'(b[3:0]));
            ext_q     = b[4];
            ext_hi_q  = '0;
            err_q     = (b[7:6] != VERSION_TWO) ? ST_VERSION : ST_OK;
            phase_q   = PH_FIXED;
        end else if (pos == 1) begin
            if (err_q == ST_OK && b[6:0] != pt_cfg)
                err_q = ST_TYPE;
        end
        if (phase_q == PH_FIXED && pos >= int'(hdr_end_q)) begin
            if (ext_q) begin
                phase_q   = PH_EXT_HDR;
                hdr_end_q = hdr_end_q + EXT_HDR;
            end else begin
                phase_q = PH_BODY;
            end
        end
        if (phase_q == PH_EXT_HDR) begin
            if (pos + 2 == int'(hdr_end_q)) begin
                ext_hi_q = b;
            end else if (pos + 1 == int'(hdr_end_q)) begin
                hdr_end_q = POS_W'(int'(hdr_end_q) + 4 * int'({ext_hi_q, b}));
                phase_q   = PH_BODY;
            end
        end
        pay = (phase_q == PH_BODY) && (pos >= int'(hdr_end_q)) && (err_q == ST_OK);
        if (lst) begin
            len = pos + 1;
            if (len < int'(FIXED_HDR))
                st = ST_SHORT;
            else if (err_q != ST_OK)
                st = err_q;
            else if (phase_q != PH_BODY || len <= int'(hdr_end_q))
                st = ST_TRUNCATED;
            else
                st = ST_OK;
            clear_parse();
        end else if (pos_q != POS_MAX) begin
            pos_q = pos_q + POS_W'(1);
        end
        x.data   = pay ? b : 8'h00;
        x.valid  = pay;
        x.last   = lst;
        x.status = lst ? st : ST_OK;
        return pay || lst;
    endfunction

    function automatic void add_row(input logic [7:0] d, input logic l,
                                    input logic t = 1'b0, input strip_out_t w = '0);
        dir_row_t r;
        r.data  = d;
        r.last  = l;
        r.typed = t;
        r.want  = w;
        dir_tab.push_back(r);
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] seen);
        if (seen !== want) begin
            $error("%s: expected %0h, got %0h", name, want, seen);
            fail_count++;
        end
    endfunction

    task automatic send_byte(input logic [7:0] d, input logic lst, input logic typed,
                             input strip_out_t want);
        strip_out_t got;
        int         gap;
        if (!src_steady) begin
            if (burst_left == 0) begin
                gap = $urandom_range(0, 5);
                if (gap > 0) begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
                burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 16);
            end
            burst_left--;
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tlast  <= lst;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        // run the predictor on every transfer so its state tracks the block
        if (strip_predict(d, lst, got) || typed)
            pending_out.push_back(typed ? want : got);
    endtask

    task automatic write_pt(input logic [6:0] v);
        s_tvalid <= 1'b0;
        while (pending_out.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        pt_cfg = v;
    endtask

    task automatic run_random_phase(input logic [6:0] pt, input int n_items, input bit squeeze);
        logic [7:0] pkt[$];
        int         kind;
        int         cc;
        int         words;
        int         cut;
        int         start;
        logic       ext;
        write_pt(pt);
        if (squeeze)
            sink_hold_req = 1'b1;
        start = items_sent;
        while (items_sent - start < n_items) begin
            pkt.delete();
            kind = $urandom_range(0, 9);
            if (kind == 9) begin
                // noise
                repeat ($urandom_range(1, 30)) pkt.push_back(8'($urandom));
            end else begin
                cc  = ($urandom_range(0, 9) == 0) ? 15 : $urandom_range(0, 2);
                ext = 1'($urandom_range(0, 1));
                pkt.push_back({VERSION_TWO, 1'($urandom), ext, 4'(cc)});
                pkt.push_back({1'($urandom), pt_cfg});
                repeat (10 + 4 * cc) pkt.push_back(8'($urandom));
                if (ext) begin
                    words = $urandom_range(0, 3);
                    pkt.push_back(8'($urandom));
                    pkt.push_back(8'($urandom));
                    pkt.push_back((kind == 7) ? 8'($urandom) : 8'h00);
                    pkt.push_back(8'(words));
                    repeat (4 * words) pkt.push_back(8'($urandom));
                end
                repeat ($urandom_range(0, 16)) pkt.push_back(8'($urandom));
                if (kind == 7) begin
                    // cut the packet short anywhere
                    cut = $urandom_range(1, pkt.size());
                    while (pkt.size() > cut) void'(pkt.pop_back());
                end else if (kind == 8) begin
                    if ($urandom_range(0, 1))
                        pkt[0][7:6] = ($urandom_range(0, 1) != 0) ? 2'b11 : 2'($urandom_range(0, 1));
                    else
                        pkt[1][6:0] = pt_cfg + 7'($urandom_range(1, 127));
                end
            end
            foreach (pkt[i])
                send_byte(pkt[i], i == pkt.size() - 1, 1'b0, '0);
        end
    endtask

    // receiver: random ready/stall runs, a long hold-off on request
    initial begin
        int run_len;
        m_tready = 1'b0;
        @(posedge aclk);
        forever begin
            if (sink_hold_req) begin
                m_tready <= 1'b0;
                repeat (SINK_HOLD) @(posedge aclk);
                sink_hold_req = 1'b0;
            end else if (sink_steady) begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end else if ($urandom_range(0, 15) == 0) begin
                m_tready <= 1'b1;
                repeat (60) @(posedge aclk);
            end else begin
                run_len = $urandom_range(1, 10);
                m_tready <= ($urandom_range(0, 2) != 0);
                repeat (run_len) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        strip_out_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_out.size() == 0) begin
                $error("output transfer with nothing expected: data %0h user %0h last %0b",
                       m_tdata, m_tuser, m_tlast);
                fail_count++;
            end else begin
                want = pending_out.pop_front();
                check_field("out_byte", want.data, m_tdata);
                check_field("out_valid", 8'(want.valid), 8'(m_tuser[0]));
                check_field("out_last", 8'(want.last), 8'(m_tlast));
                check_field("status", 8'(want.status), 8'(m_tuser[3:1]));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        pt_cfg      = DEFAULT_PT;
        clear_parse();

        // lone byte: too short, even with bad version
        add_row(8'hFF, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, ST_SHORT});
        // version 0, full-length header
        add_row(8'h00, 1'b0);
        for (int k = 0; k < 10; k++)
            add_row(k[0] ? 8'hFF : 8'h00, 1'b0);
        add_row(8'hFF, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, ST_VERSION});
        // version 2, payload type 127 against default
        add_row(8'h80, 1'b0);
        add_row(8'hFF, 1'b0);
        for (int k = 0; k < 9; k++)
            add_row(k[0] ? 8'h00 : 8'hFF, 1'b0);
        add_row(8'h00, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, ST_TYPE});
        // minimal good packet with two payload bytes
        add_row(8'h80, 1'b0);
        add_row(8'h60, 1'b0);
        for (int k = 0; k < 10; k++)
            add_row(k[0] ? 8'h00 : 8'hFF, 1'b0);
        add_row(8'h00, 1'b0);
        add_row(8'hFF, 1'b1, 1'b1, '{8'hFF, 1'b1, 1'b1, ST_OK});

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_tab[i])
            send_byte(dir_tab[i].data, dir_tab[i].last, dir_tab[i].typed, dir_tab[i].want);

        run_random_phase(7'd0, PHASE_ITEMS, 1'b0);
        run_random_phase(7'd127, PHASE_ITEMS, 1'b1);
        run_random_phase(7'($urandom), PHASE_ITEMS, 1'b0);
        run_random_phase(DEFAULT_PT, PHASE_ITEMS, 1'b0);

        // one longer packet at full rate
        write_pt(7'($urandom));
        src_steady  = 1'b1;
        sink_steady = 1'b1;
        send_byte({VERSION_TWO, 6'h00}, 1'b0, 1'b0, '0);
        send_byte({1'b0, pt_cfg}, 1'b0, 1'b0, '0);
        repeat (10) send_byte(8'($urandom), 1'b0, 1'b0, '0);
        for (int k = 12; k < LONG_LEN; k++)
            send_byte(8'($urandom), k == LONG_LEN - 1, 1'b0, '0);
        s_tvalid <= 1'b0;

        while (pending_out.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* filelist.f */
design/rhs_pkg.sv
design/rtp_header_stripper.sv
design/rhs_checker.sv
tb/sv/rtp_header_stripper_test.sv
